>>> sv/gndf_pkg.sv
// Shared constants, types and register codes for the graduated density filter.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package gndf_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int COORD_BITS = 16;

    localparam int IN_BITS     = 2 * COORD_BITS + 3 * PIXEL_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 3 * PIXEL_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // front-end arithmetic widths
    localparam int PX_W  = COORD_BITS + 32;
    localparam int SX_W  = COORD_BITS + 19;
    localparam int MS_W  = 16 + SX_W;
    localparam int P_W   = MS_W + 2;
    localparam int Q_W   = P_W - 13;
    localparam int LEN_W = Q_W + 17;

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam int          EXP_TERMS = 10;

    localparam int NUM_W = PIXEL_BITS + 32;

    // pipeline depth per section
    localparam int FRONT_ST = 8;
    localparam int EXP_ST   = 3 * EXP_TERMS + 1;
    localparam int LANE_ST  = PIXEL_BITS + 2;
    localparam int PIX_ST   = FRONT_ST + EXP_ST;
    localparam int NST      = FRONT_ST + EXP_ST + LANE_ST;

    localparam int PADDR_W = 6;

    typedef enum logic [2:0] {
        REG_SCALE_X   = 3'd0,
        REG_SCALE_Y   = 3'd1,
        REG_SIN       = 3'd2,
        REG_COS       = 3'd3,
        REG_OFFSET    = 3'd4,
        REG_GAIN      = 3'd5,
        REG_DENSITY   = 3'd6,
        REG_TINT      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] scale_x;
        logic [31:0] scale_y;
        logic [15:0] sin_term;
        logic [15:0] cos_term;
        logic [15:0] offset_term;
        logic [15:0] gradient_gain;
        logic [15:0] density;
        logic [47:0] tint;
    } cfg_t;

endpackage

`default_nettype wire

>>> sv/gndf_front.sv
// Coordinate mapping, rotation, gain, clip and exponent split: eight stages.
// Depends on gndf_pkg; produces the Q.30 exponent fraction and the shift count.
`default_nettype none

module gndf_front import gndf_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  cfg_t                  cfg,
    input  logic [COORD_BITS-1:0] column,
    input  logic [COORD_BITS-1:0] row,
    output logic [29:0]           x_out,
    output logic [3:0]            n_out
);

    logic [PX_W-1:0]         px_reg, py_reg;
    logic signed [SX_W-1:0]  sx_reg, sy_reg;
    logic signed [MS_W-1:0]  ms_reg, mc_reg;
    logic signed [Q_W-1:0]   q_reg;
    logic signed [LEN_W-1:0] len_reg;
    logic [16:0]             t_reg;
    logic [31:0]             e_reg;
    logic [29:0]             x_reg;
    logic [3:0]              n_reg;

    logic signed [15:0]      sin_s, cos_s, off_s;
    logic signed [Q_W-1:0]   q_next;
    logic signed [29:0]      len_clip;
    logic [29:0]             t_sum;
    logic [57:0]             x_prod;

    // v = p - 2^31, then round to nearest by 2^15, halves away from zero
    function automatic logic signed [SX_W-1:0] map_rs(input logic [PX_W-1:0] p);
        logic [PX_W:0] v;
        logic          neg;
        logic [PX_W:0] mag;
        logic [PX_W:0] mr;
        v   = {1'b0, p} - (PX_W+1)'(32'h8000_0000);
        neg = v[PX_W];
        mag = neg ? -v : v;
        mr  = (mag + (PX_W+1)'(16384)) >> 15;
        return neg ? -SX_W'(mr) : SX_W'(mr);
    endfunction

    assign sin_s = $signed(cfg.sin_term);
    assign cos_s = $signed(cfg.cos_term);
    assign off_s = $signed(cfg.offset_term);

    always_comb begin
        logic [P_W-1:0] p;
        logic           neg;
        logic [P_W-1:0] mag;
        logic [P_W-1:0] mr;
        p      = P_W'(ms_reg) - P_W'(mc_reg) + (P_W'(off_s) << 16);
        neg    = p[P_W-1];
        mag    = neg ? -p : p;
        mr     = (mag + P_W'(8192)) >> 14;
        q_next = neg ? -Q_W'(mr) : Q_W'(mr);
    end

    always_comb begin
        if (len_reg > LEN_W'(64'sd268435456)) begin
            len_clip = 30'sd268435456;
        end else if (len_reg < -LEN_W'(64'sd268435456)) begin
            len_clip = -30'sd268435456;
        end else begin
            len_clip = 30'(len_reg);
        end
        t_sum = 30'(len_clip) + 30'd268439552;
    end

    assign x_prod = 58'(e_reg[27:0]) * 58'(LN2_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg  <= PX_W'(column) * PX_W'(cfg.scale_x);
            py_reg  <= PX_W'(row) * PX_W'(cfg.scale_y);
            sx_reg  <= map_rs(px_reg);
            sy_reg  <= map_rs(py_reg);
            ms_reg  <= MS_W'(sin_s) * MS_W'(sx_reg);
            mc_reg  <= MS_W'(cos_s) * MS_W'(sy_reg);
            q_reg   <= q_next;
            len_reg <= LEN_W'(q_reg) * LEN_W'($signed({1'b0, cfg.gradient_gain}));
            t_reg   <= t_sum[29:13];
            e_reg   <= 32'(cfg.density) * 32'(t_reg);
            x_reg   <= x_prod[57:28];
            n_reg   <= e_reg[31:28];
        end
    end

    assign x_out = x_reg;
    assign n_out = n_reg;

endmodule

`default_nettype wire

>>> sv/gndf_exp.sv
// Pipelined exp(-x) by Horner terms, three stages per term, then the 2^-n shift.
// Depends on gndf_pkg; feeds the attenuation to the channel lanes.
`default_nettype none

module gndf_exp import gndf_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [29:0] x_in,
    input  logic [3:0]  n_in,
    output logic [30:0] a_out
);

    logic [29:0] xt_in [EXP_TERMS];
    logic [3:0]  nt_in [EXP_TERMS];
    logic [30:0] rt_in [EXP_TERMS];

    logic [29:0] xa_reg [EXP_TERMS];
    logic [29:0] xb_reg [EXP_TERMS];
    logic [29:0] xc_reg [EXP_TERMS];
    logic [3:0]  na_reg [EXP_TERMS];
    logic [3:0]  nb_reg [EXP_TERMS];
    logic [3:0]  nc_reg [EXP_TERMS];
    logic [30:0] pa_reg [EXP_TERMS];
    logic [30:0] pb_reg [EXP_TERMS];
    logic [30:0] qb_reg [EXP_TERMS];
    logic [30:0] rc_reg [EXP_TERMS];
    logic [30:0] a_reg;

    for (genvar t = 0; t < EXP_TERMS; t++) begin : g_term
        localparam int          K = EXP_TERMS - t;
        localparam logic [32:0] M = 33'((64'd1 << 32) / K);

        logic [60:0] prod;
        logic [63:0] qm;
        logic [34:0] rem;
        logic [30:0] q;

        if (t == 0) begin : g_first
            assign xt_in[t] = x_in;
            assign nt_in[t] = n_in;
            assign rt_in[t] = 31'(1 << 30);
        end else begin : g_next
            assign xt_in[t] = xc_reg[t-1];
            assign nt_in[t] = nc_reg[t-1];
            assign rt_in[t] = rc_reg[t-1];
        end

        assign prod = 61'(xt_in[t]) * 61'(rt_in[t]);
        assign qm   = 64'(pa_reg[t]) * 64'(M);
        // reciprocal estimate is low by at most one
        assign rem  = 35'(pb_reg[t]) - 35'(qb_reg[t]) * 35'(K);
        assign q    = qb_reg[t] + 31'(rem >= 35'(K));

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[t] <= prod[60:30];
                xa_reg[t] <= xt_in[t];
                na_reg[t] <= nt_in[t];
                qb_reg[t] <= qm[62:32];
                pb_reg[t] <= pa_reg[t];
                xb_reg[t] <= xa_reg[t];
                nb_reg[t] <= na_reg[t];
                rc_reg[t] <= 31'(1 << 30) - q;
                xc_reg[t] <= xb_reg[t];
                nc_reg[t] <= nb_reg[t];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= rc_reg[EXP_TERMS-1] >> nc_reg[EXP_TERMS-1];
        end
    end

    assign a_out = a_reg;

endmodule

`default_nettype wire

>>> sv/gndf_lane.sv
// One channel lane: tint denominator, rounded numerator, one quotient bit a stage.
// Depends on gndf_pkg; three copies run side by side in the top level.
`default_nettype none

module gndf_lane import gndf_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [30:0]           a_in,
    input  logic [15:0]           tint_ch,
    input  logic [PIXEL_BITS-1:0] pix_in,
    output logic [PIXEL_BITS-1:0] q_out
);

    logic [30:0]           d1_reg, a1_reg, d2_reg;
    logic [PIXEL_BITS-1:0] v1_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [46:0]           dm;

    logic [NUM_W-1:0]      rem_reg [PIXEL_BITS];
    logic [30:0]           dd_reg  [PIXEL_BITS];
    logic [PIXEL_BITS-1:0] q_reg   [PIXEL_BITS];

    assign dm = 47'(31'(1 << 30) - a_in) * 47'(tint_ch);

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg  <= 31'(1 << 30) - dm[46:16];
            a1_reg  <= a_in;
            v1_reg  <= pix_in;
            num_reg <= NUM_W'(v1_reg) * NUM_W'(a1_reg) + NUM_W'(d1_reg >> 1);
            d2_reg  <= d1_reg;
        end
    end

    for (genvar i = 0; i < PIXEL_BITS; i++) begin : g_div
        localparam int B = PIXEL_BITS - 1 - i;

        logic [NUM_W-1:0]      r_in;
        logic [30:0]           d_in;
        logic [PIXEL_BITS-1:0] qi;
        logic [NUM_W:0]        sh;
        logic                  take;

        if (i == 0) begin : g_first
            assign r_in = num_reg;
            assign d_in = d2_reg;
            assign qi   = '0;
        end else begin : g_next
            assign r_in = rem_reg[i-1];
            assign d_in = dd_reg[i-1];
            assign qi   = q_reg[i-1];
        end

        assign sh   = (NUM_W+1)'(d_in) << B;
        assign take = {1'b0, r_in} >= sh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= take ? NUM_W'({1'b0, r_in} - sh) : r_in;
                dd_reg[i]  <= d_in;
                q_reg[i]   <= take ? (qi | (PIXEL_BITS'(1) << B)) : qi;
            end
        end
    end

    assign q_out = q_reg[PIXEL_BITS-1];

endmodule

`default_nettype wire

>>> sv/graduated_density_filter.sv
// Graduated density filter top level: register port, pipeline control, lanes, output.
// Depends on gndf_pkg, gndf_front, gndf_exp and gndf_lane.
//
// Usage:
//   s_ channel: one pixel per item, tdata = column, row, red, green, blue.
//   m_ channel: one result per item, tdata = red, green, blue (attenuated).
//   APB port: eight registers at byte address 8*i, 64-bit data, no wait states.
//   Write registers only while no item is in flight.
// Throughput: one item per clock while m_tready stays high; every stage holds one item and
//   the pipeline has no feedback between items.
// Pipeline: acceptance to m_tvalid passes 8 front-end stages, 3 per exp term plus the
//   shift, 2 lane set-up stages and one quotient bit per stage in each lane's divider.
// Reset: synchronous, active low; drops every valid, the skid and the output,
//   and loads the register defaults.
// Stall: the output register holds its item; one more item lands in a skid
//   register, and then the pipeline and s_tready hold until m_tready returns.
`default_nettype none

module graduated_density_filter import gndf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // column, row, red_in, green_in, blue_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // red_out, green_out, blue_out
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    cfg_t                  cfg_reg;
    logic [NST-1:0]        vld_reg;
    logic [3*PIXEL_BITS-1:0] pix_reg [PIX_ST];
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [OUT_BITS-1:0]   skid_data_reg, skid_data_next;

    logic                  en;
    logic [29:0]           x_w;
    logic [3:0]            n_w;
    logic [30:0]           a_w;
    logic [OUT_BITS-1:0]   res;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_x       <= '0;
            cfg_reg.scale_y       <= '0;
            cfg_reg.sin_term      <= '0;
            cfg_reg.cos_term      <= 16'd16384;
            cfg_reg.offset_term   <= '0;
            cfg_reg.gradient_gain <= 16'd8192;
            cfg_reg.density       <= 16'd8192;
            cfg_reg.tint          <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                REG_SCALE_X: cfg_reg.scale_x       <= pwdata[31:0];
                REG_SCALE_Y: cfg_reg.scale_y       <= pwdata[31:0];
                REG_SIN:     cfg_reg.sin_term      <= pwdata[15:0];
                REG_COS:     cfg_reg.cos_term      <= pwdata[15:0];
                REG_OFFSET:  cfg_reg.offset_term   <= pwdata[15:0];
                REG_GAIN:    cfg_reg.gradient_gain <= pwdata[15:0];
                REG_DENSITY: cfg_reg.density       <= pwdata[15:0];
                REG_TINT:    cfg_reg.tint          <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SCALE_X: prdata = 64'(cfg_reg.scale_x);
            REG_SCALE_Y: prdata = 64'(cfg_reg.scale_y);
            REG_SIN:     prdata = 64'(cfg_reg.sin_term);
            REG_COS:     prdata = 64'(cfg_reg.cos_term);
            REG_OFFSET:  prdata = 64'(cfg_reg.offset_term);
            REG_GAIN:    prdata = 64'(cfg_reg.gradient_gain);
            REG_DENSITY: prdata = 64'(cfg_reg.density);
            REG_TINT:    prdata = 64'(cfg_reg.tint);
            default:     prdata = '0;
        endcase
    end

    // whole pipeline advances unless the skid holds an item
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // carry the channels alongside the attenuation path
    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg[0] <= s_tdata[2*COORD_BITS +: 3*PIXEL_BITS];
            for (int i = 1; i < PIX_ST; i++) begin
                pix_reg[i] <= pix_reg[i-1];
            end
        end
    end

    gndf_front u_front (
        .aclk   (aclk),
        .en     (en),
        .cfg    (cfg_reg),
        .column (s_tdata[COORD_BITS-1:0]),
        .row    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .x_out  (x_w),
        .n_out  (n_w)
    );

    gndf_exp u_exp (
        .aclk  (aclk),
        .en    (en),
        .x_in  (x_w),
        .n_in  (n_w),
        .a_out (a_w)
    );

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        gndf_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .a_in    (a_w),
            .tint_ch (cfg_reg.tint[16*ch +: 16]),
            .pix_in  (pix_reg[PIX_ST-1][PIXEL_BITS*ch +: PIXEL_BITS]),
            .q_out   (res[PIXEL_BITS*ch +: PIXEL_BITS])
        );
    end

    // merge the lanes into the output register, with one skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (vld_reg[NST-1]) begin
            if (!out_valid_reg || m_tready) begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

`default_nettype wire

>>> sv/gndf_checker.sv
// Port-level checks for the graduated density filter, bound to the top level.
// Depends on gndf_pkg and on the port list of graduated_density_filter.
`default_nettype none

module gndf_port_checks import gndf_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [PADDR_W-1:0]     paddr,
    input logic [63:0]            pwdata,
    input logic [63:0]            prdata,
    input logic                   pready
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item dropped or changed while stalled");

    // reset empties the output and frees the input
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset left an item or a stall behind");

    // after a write to the density register, it reads back the written value
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && psel && penable && pwrite && pready &&
        paddr[PADDR_W-1:3] == REG_DENSITY
        |=> paddr[PADDR_W-1:3] != REG_DENSITY || prdata[15:0] == $past(pwdata[15:0]))
        else $error("density register read-back mismatch");

    // a stalled input means the skid holds an item, so an accepted output frees the input
    a_stall_release: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("input stayed stalled after the output drained");

endmodule

bind graduated_density_filter gndf_port_checks u_gndf_port_checks (.*);

`default_nettype wire

>>> dv/gndf_checker.sv
// Checker for the graduated density filter: tracks register writes on the APB port,
// predicts each pixel's result and compares it with the m_ channel in order.
// Depends on gndf_pkg.
`default_nettype none

module gndf_checker import gndf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // column, row, red_in, green_in, blue_in
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // red_out, green_out, blue_out
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [63:0]            pwdata,
    output int                     pending,
    output int                     fail_count,
    output int                     checked_count
);

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgb_t;

    cfg_t regs;
    rgb_t expected_rgb[$];

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    function automatic longint map_coord(logic [15:0] c, logic [31:0] scale);
        longint p;
        p = longint'(c) * longint'(scale);
        return round_shift(p - (longint'(1) << 31), 15);
    endfunction

    function automatic rgb_t filtered_pixel(logic [IN_TDATA_W-1:0] px);
        longint sx, sy, py, len;
        longint unsigned t, e, n, f, x, r, a, c, d, v;
        logic [15:0] chan [3];
        rgb_t res;
        sx = map_coord(px[15:0], regs.scale_x);
        sy = map_coord(px[31:16], regs.scale_y);
        py = longint'($signed(regs.sin_term)) * sx - longint'($signed(regs.cos_term)) * sy
             + longint'($signed(regs.offset_term)) * 65536;
        len = round_shift(py, 14) * longint'(regs.gradient_gain);
        if (len > (longint'(1) << 28)) len = longint'(1) << 28;
        if (len < -(longint'(1) << 28)) len = -(longint'(1) << 28);
        t = longint'(len + (longint'(1) << 28) + 4096) >>> 13;
        e = longint'(regs.density) * t;
        n = e >> 28;
        f = e & ((64'd1 << 28) - 1);
        x = (f * 64'd744261118) >> 28;
        r = 64'd1 << 30;
        // Horner series for exp(-x), highest term first
        for (int k = EXP_TERMS; k >= 1; k--) begin
            r = (64'd1 << 30) - ((x * r) >> 30) / longint'(k);
        end
        a = (n > 63) ? 0 : (r >> n);
        chan[0] = px[47:32];
        chan[1] = px[63:48];
        chan[2] = px[79:64];
        for (int ch = 0; ch < 3; ch++) begin
            c = regs.tint[16*ch +: 16];
            d = (64'd1 << 30) - ((((64'd1 << 30) - a) * c) >> 16);
            v = chan[ch];
            chan[ch] = 16'((v * a + d / 2) / d);
        end
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        return res;
    endfunction

    always @(posedge aclk) begin
        rgb_t got;
        rgb_t want;
        if (!aresetn) begin
            regs.scale_x <= '0;
            regs.scale_y <= '0;
            regs.sin_term <= '0;
            regs.cos_term <= 16'd16384;
            regs.offset_term <= '0;
            regs.gradient_gain <= 16'd8192;
            regs.density <= 16'd8192;
            regs.tint <= '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[5:3]))
                    REG_SCALE_X: regs.scale_x <= pwdata[31:0];
                    REG_SCALE_Y: regs.scale_y <= pwdata[31:0];
                    REG_SIN:     regs.sin_term <= pwdata[15:0];
                    REG_COS:     regs.cos_term <= pwdata[15:0];
                    REG_OFFSET:  regs.offset_term <= pwdata[15:0];
                    REG_GAIN:    regs.gradient_gain <= pwdata[15:0];
                    REG_DENSITY: regs.density <= pwdata[15:0];
                    REG_TINT:    regs.tint <= pwdata[47:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_rgb.push_back(filtered_pixel(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[47:0];
                checked_count <= checked_count + 1;
                if (expected_rgb.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                            || got.blue !== want.blue) begin
                        $display("%0t: mismatch, expected r=%h g=%h b=%h, actual r=%h g=%h b=%h",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        checked_count = 0;
    end

    assign pending = expected_rgb.size();

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Top of the graduated density filter testbench: clock, reset, register set-up,
// pixel stimulus and result back-pressure. Depends on gndf_pkg, gndf_checker and graduated_density_filter.
`default_nettype none

module tb_top;
    import gndf_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]     paddr;
    logic [63:0]            pwdata, prdata;

    int  pending, fail_count, checked_count;
    int  pixels_sent;
    bit  sender_gaps, receiver_stalls, long_hold;
    int  width_x, width_y;

    graduated_density_filter i_dut (.*);

    gndf_checker i_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #4000000;
        $display("tb_top failed");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int n;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            n = receiver_stalls ? $urandom_range(0, 10) : 0;
            if (long_hold) begin
                n = 300;
                long_hold = 0;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 3;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic send_pixel(logic [IN_TDATA_W-1:0] px);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic load_regs(logic [31:0] sx, logic [31:0] sy, logic [15:0] sn,
                             logic [15:0] cs, logic [15:0] off, logic [15:0] gain,
                             logic [15:0] dens, logic [47:0] tint);
        reg_write(REG_SCALE_X, 64'(sx));
        reg_write(REG_SCALE_Y, 64'(sy));
        reg_write(REG_SIN, 64'(sn));
        reg_write(REG_COS, 64'(cs));
        reg_write(REG_OFFSET, 64'(off));
        reg_write(REG_GAIN, 64'(gain));
        reg_write(REG_DENSITY, 64'(dens));
        reg_write(REG_TINT, 64'(tint));
    endtask

    // frame-like set-up: scales from an image size, trig from an angle
    task automatic load_frame_regs();
        real ang;
        width_x = $urandom_range(16, 4096);
        width_y = $urandom_range(16, 4096);
        ang = $urandom_range(0, 359) * 3.14159265 / 180.0;
        load_regs(32'((64'd1 << 32) / width_x), 32'((64'd1 << 32) / width_y),
                  16'($rtoi($sin(ang) * 16384.0)), 16'($rtoi($cos(ang) * 16384.0)),
                  16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(1024, 20000)),
                  16'($urandom_range(0, 32768)), 48'({$urandom, $urandom}));
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack_pixel(logic [15:0] c, logic [15:0] r,
                                                         logic [15:0] red, logic [15:0] g,
                                                         logic [15:0] b);
        return {b, g, red, r, c};
    endfunction

    initial begin
        logic [15:0] corner [4];
        int phase_count;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        sender_gaps = 1;
        receiver_stalls = 1;
        long_hold = 0;
        pixels_sent = 0;
        phase_count = 0;
        corner = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner pixels on reset defaults, then extreme register settings
        for (int i = 0; i < 4; i++) begin
            send_pixel(pack_pixel(corner[i], corner[3-i], corner[i], corner[(i+1)%4],
                                  corner[(i+2)%4]));
        end
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            case (p)
                0: load_regs('1, '1, 16'h7FFF, 16'h8000, 16'h4000, 16'hFFFF, 16'hFFFF, '1);
                1: load_regs('0, '1, 16'hC000, 16'h4000, 16'hC000, 16'h0000, 16'h0000, '0);
                2: load_regs(32'h0010_0000, 32'h0010_0000, 16'h0000, 16'h4000, 16'h0000,
                             16'h2000, 16'h8000, 48'hFFFF_0000_8000);
                3: load_regs('1, '0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h1000, 16'h1000,
                             48'h8000_FFFF_0000);
                default: load_regs('0, '0, 16'h4000, 16'hC000, 16'h0001, 16'h0001,
                                   16'hFFFF, '1);
            endcase
            for (int i = 0; i < 4; i++) begin
                send_pixel(pack_pixel(corner[i], corner[(i+1)%4], corner[3-i],
                                      corner[i], corner[(i+3)%4]));
            end
        end

        // random phases: frame-like set-ups mostly, raw register patterns otherwise
        for (int p = 0; p < 10; p++) begin
            wait_idle();
            phase_count++;
            sender_gaps = (p % 3) != 1;
            receiver_stalls = (p % 4) != 2;
            if (p % 3 == 2) begin
                width_x = 65535;
                width_y = 65535;
                load_regs($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 48'({$urandom, $urandom}));
            end else begin
                load_frame_regs();
            end
            if (p == 4) begin
                sender_gaps = 0;
                long_hold = 1;
            end
            for (int i = 0; i < 108; i++) begin
                if (i % 8 == 7) begin
                    send_pixel(pack_pixel(16'($urandom), 16'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom)));
                end else begin
                    send_pixel(pack_pixel(16'($urandom_range(0, width_x)),
                                          16'($urandom_range(0, width_y)),
                                          16'($urandom), 16'($urandom), 16'($urandom)));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        $display("Sent %0d pixels over %0d random register set-ups plus corner settings;",
                 pixels_sent, phase_count);
        $display("checked %0d results, %0d left outstanding.", checked_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
